// ----- src/brta_pkg.sv -----
`timescale 1ns / 1ps

package brta_pkg;

  // request modes
  localparam logic [1:0] MODE_ADD_MEM = 2'd0;
  localparam logic [1:0] MODE_ADD_RES = 2'd1;
  localparam logic [1:0] MODE_FIND    = 2'd2;

  // result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;

  // datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_IDX_INC,
    OP_IDX_DEC,
    OP_WR_MOD,
    OP_DROP_BEGIN,
    OP_SHIFT_WR,
    OP_SHIFT_END,
    OP_WR_EMPTY,
    OP_INS_BEGIN,
    OP_INS_MOVE,
    OP_INS_PLACE,
    OP_INS_FIX0,
    OP_F_WIN,
    OP_F_CAND,
    OP_F_LOOP,
    OP_R_INC,
    OP_R_STEP
  } dp_op_t;

  // table read address source
  typedef enum logic [2:0] {
    RA_IDX,
    RA_JDX,
    RA_JDX_INC,
    RA_JDX_DEC,
    RA_ZERO
  } rsel_t;

  typedef struct packed {
    dp_op_t     op;
    rsel_t      rsel;
    logic       fin;
    logic [1:0] fin_status;
    logic       fin_hit;
  } brta_cmd_t;

  typedef struct packed {
    logic idx_lt_cnt;
    logic idx_zero;
    logic shift_more;
    logic jdx_zero;
    logic empty;
    logic full;
    logic a_brk;
    logic a_cov;
    logic a_mod_done;
    logic a_drop;
    logic i_less;
    logic f_small;
    logic f_below;
    logic w_bad;
    logic lo_le_cand;
    logic jdx_lt_rcnt;
    logic r_meet;
    logic r_short;
  } brta_stat_t;

endpackage

// ----- src/brta_ram.sv -----
`timescale 1ns / 1ps

module brta_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/brta_ctrl.sv -----
`timescale 1ns / 1ps

module brta_ctrl import brta_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_mode,
  input  brta_stat_t stat,
  output brta_cmd_t  cmd,
  output logic       busy
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_A_RD,
    S_A_EV,
    S_A_MOD,
    S_SH_RD,
    S_SH_WR,
    S_A_POST,
    S_I_RD,
    S_I_EV,
    S_I_C0RD,
    S_I_C0EV,
    S_F_NEXT,
    S_F_RD,
    S_F_EV,
    S_F_CAND,
    S_F_LOOP,
    S_R_RD,
    S_R_EV
  } state_t;

  state_t state_r, state_nxt;

  // next state and command
  always_comb begin
    state_nxt      = state_r;
    cmd.op         = OP_NONE;
    cmd.rsel       = RA_IDX;
    cmd.fin        = 1'b0;
    cmd.fin_status = ST_DONE;
    cmd.fin_hit    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op = OP_LOAD;
          case (in_mode) inside
            MODE_ADD_MEM, MODE_ADD_RES: state_nxt = S_A_RD;
            MODE_FIND:                  state_nxt = S_F_NEXT;
            default:                    cmd.fin   = 1'b1;
          endcase
        end
      end
      // merge scan over the table
      S_A_RD: begin
        state_nxt = stat.idx_lt_cnt ? S_A_EV : S_A_POST;
      end
      S_A_EV: begin
        if (stat.a_brk) begin
          state_nxt = S_A_POST;
        end else if (stat.a_cov) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end else if (stat.a_mod_done) begin
          state_nxt = S_A_MOD;
        end else if (stat.a_drop) begin
          cmd.op    = OP_DROP_BEGIN;
          state_nxt = S_SH_RD;
        end else begin
          cmd.op    = OP_IDX_INC;
          state_nxt = S_A_RD;
        end
      end
      S_A_MOD: begin
        cmd.op    = OP_WR_MOD;
        cmd.fin   = 1'b1;
        state_nxt = S_IDLE;
      end
      // close the gap left by a merged entry
      S_SH_RD: begin
        cmd.rsel = RA_JDX_INC;
        if (stat.shift_more) begin
          state_nxt = S_SH_WR;
        end else begin
          cmd.op    = OP_SHIFT_END;
          state_nxt = S_A_RD;
        end
      end
      S_SH_WR: begin
        cmd.op    = OP_SHIFT_WR;
        state_nxt = S_SH_RD;
      end
      S_A_POST: begin
        if (stat.empty) begin
          cmd.op    = OP_WR_EMPTY;
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end else if (stat.full) begin
          cmd.fin        = 1'b1;
          cmd.fin_status = ST_FULL;
          state_nxt      = S_IDLE;
        end else begin
          cmd.op    = OP_INS_BEGIN;
          state_nxt = S_I_RD;
        end
      end
      // sorted insert, moving entries up from the top
      S_I_RD: begin
        cmd.rsel  = RA_JDX_DEC;
        state_nxt = stat.jdx_zero ? S_I_C0RD : S_I_EV;
      end
      S_I_EV: begin
        if (stat.i_less) begin
          cmd.op    = OP_INS_MOVE;
          state_nxt = S_I_RD;
        end else begin
          cmd.op    = OP_INS_PLACE;
          state_nxt = S_I_C0RD;
        end
      end
      S_I_C0RD: begin
        cmd.rsel  = RA_ZERO;
        state_nxt = S_I_C0EV;
      end
      S_I_C0EV: begin
        cmd.op    = OP_INS_FIX0;
        cmd.fin   = 1'b1;
        state_nxt = S_IDLE;
      end
      // find: memory entries from the top down
      S_F_NEXT: begin
        if (stat.idx_zero) begin
          cmd.fin        = 1'b1;
          cmd.fin_status = ST_NOSPACE;
          state_nxt      = S_IDLE;
        end else begin
          cmd.op    = OP_IDX_DEC;
          state_nxt = S_F_RD;
        end
      end
      S_F_RD: begin
        state_nxt = S_F_EV;
      end
      S_F_EV: begin
        if (stat.f_small) begin
          state_nxt = S_F_NEXT;
        end else if (stat.f_below) begin
          cmd.fin        = 1'b1;
          cmd.fin_status = ST_NOSPACE;
          state_nxt      = S_IDLE;
        end else begin
          cmd.op    = OP_F_WIN;
          state_nxt = S_F_CAND;
        end
      end
      S_F_CAND: begin
        if (stat.w_bad) begin
          state_nxt = S_F_NEXT;
        end else begin
          cmd.op    = OP_F_CAND;
          state_nxt = S_F_LOOP;
        end
      end
      S_F_LOOP: begin
        if (!stat.lo_le_cand) begin
          state_nxt = S_F_NEXT;
        end else begin
          cmd.op    = OP_F_LOOP;
          state_nxt = S_R_RD;
        end
      end
      // reserved scan for the current candidate
      S_R_RD: begin
        cmd.rsel = RA_JDX;
        if (!stat.jdx_lt_rcnt) begin
          cmd.fin     = 1'b1;
          cmd.fin_hit = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          state_nxt = S_R_EV;
        end
      end
      S_R_EV: begin
        if (stat.r_meet) begin
          if (stat.r_short) begin
            state_nxt = S_F_NEXT;
          end else begin
            cmd.op    = OP_R_STEP;
            state_nxt = S_F_LOOP;
          end
        end else begin
          cmd.op    = OP_R_INC;
          state_nxt = S_R_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ----- src/brta_dp.sv -----
`timescale 1ns / 1ps

module brta_dp import brta_pkg::*; #(
  parameter int MAX_REGIONS = 128,
  parameter int PAGE_BYTES  = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  brta_cmd_t   cmd,
  output brta_stat_t  stat,
  input  logic [1:0]  in_mode,
  input  logic [63:0] in_start_addr,
  input  logic [63:0] in_length,
  input  logic [63:0] in_end_limit,
  input  logic [30:0] in_alignment,
  input  logic        cfg_valid,
  input  logic [63:0] cfg_alloc_limit,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [63:0] out_found_addr
);

  localparam int AW = $clog2(MAX_REGIONS);
  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_REGIONS);
  localparam logic [63:0]   PAGE    = 64'(PAGE_BYTES);

  // control state (reset)
  logic [CW-1:0] mcnt_r, mcnt_nxt, rcnt_r, rcnt_nxt;
  logic          mz_r, mz_nxt, rz_r, rz_nxt;
  logic          ms0z_r, ms0z_nxt, rs0z_r, rs0z_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [63:0]   lim_r, lim_nxt;

  // working registers
  logic [63:0]   base_r, base_nxt, end_r, end_nxt, size_r, size_nxt;
  logic [63:0]   start_r, start_nxt, mask_r, mask_nxt;
  logic [63:0]   lo_r, lo_nxt, top_r, top_nxt;
  logic [63:0]   cand_r, cand_nxt, cand_end_r, cand_end_nxt, rend_r, rend_nxt;
  logic [CW-1:0] idx_r, idx_nxt, jdx_r, jdx_nxt;
  logic          tsel_r, tsel_nxt;
  logic          mzq_r, mzq_nxt, rzq_r, rzq_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [63:0]   out_addr_r, out_addr_nxt;

  // table ports
  logic [AW-1:0]  r_addr, w_addr;
  logic [127:0]   w_data, m_rdata, r_rdata;
  logic           w_en, m_we, r_we;
  logic [CW-1:0]  jdx_inc, jdx_dec;

  // read data and derived values
  logic [63:0]   m_base, m_size, r_base, r_size, t_base, t_size, t_end, m_top;
  logic [CW-1:0] t_cnt;
  logic          t_s0z, a_mod;
  logic [63:0]   reg_size, mod_size;
  logic [CW-1:0] tc;
  logic          tz, ts0;

  assign jdx_inc = jdx_r + CW'(1);
  assign jdx_dec = jdx_r - CW'(1);

  // shared read address for both tables
  always_comb begin
    case (cmd.rsel)
      RA_IDX:     r_addr = idx_r[AW-1:0];
      RA_JDX:     r_addr = jdx_r[AW-1:0];
      RA_JDX_INC: r_addr = jdx_inc[AW-1:0];
      RA_JDX_DEC: r_addr = jdx_dec[AW-1:0];
      default:    r_addr = '0;
    endcase
  end

  assign m_we = w_en && !tsel_r;
  assign r_we = w_en && tsel_r;

  brta_ram #(.WIDTH(128), .DEPTH(MAX_REGIONS)) u_mem_tbl (
    .clk   (clk),
    .we    (m_we),
    .waddr (w_addr),
    .wdata (w_data),
    .raddr (r_addr),
    .rdata (m_rdata)
  );

  brta_ram #(.WIDTH(128), .DEPTH(MAX_REGIONS)) u_res_tbl (
    .clk   (clk),
    .we    (r_we),
    .waddr (w_addr),
    .wdata (w_data),
    .raddr (r_addr),
    .rdata (r_rdata)
  );

  // entry zero reads as cleared until first written
  assign mzq_nxt = mz_r && (r_addr == '0);
  assign rzq_nxt = rz_r && (r_addr == '0);
  assign m_base  = mzq_r ? 64'd0 : m_rdata[127:64];
  assign m_size  = mzq_r ? 64'd0 : m_rdata[63:0];
  assign r_base  = rzq_r ? 64'd0 : r_rdata[127:64];
  assign r_size  = rzq_r ? 64'd0 : r_rdata[63:0];

  // table under an add
  assign t_base = tsel_r ? r_base : m_base;
  assign t_size = tsel_r ? r_size : m_size;
  assign t_cnt  = tsel_r ? rcnt_r : mcnt_r;
  assign t_s0z  = tsel_r ? rs0z_r : ms0z_r;
  assign t_end  = t_base + t_size;
  assign m_top  = m_base + m_size;
  assign a_mod  = (base_r < t_base) && (end_r >= t_base);

  assign reg_size = end_r - base_r;
  assign mod_size = rend_r - base_r;

  // status to the controller
  assign stat.idx_lt_cnt  = idx_r < t_cnt;
  assign stat.idx_zero    = idx_r == '0;
  assign stat.shift_more  = jdx_inc < t_cnt;
  assign stat.jdx_zero    = jdx_r == '0;
  assign stat.empty       = (t_cnt == CNT_ONE) && t_s0z;
  assign stat.full        = t_cnt >= CNT_MAX;
  assign stat.a_brk       = (t_base > end_r) || (t_size == 64'd0);
  assign stat.a_cov       = (t_base <= base_r) && (t_end >= end_r);
  assign stat.a_mod_done  = a_mod && (t_end >= end_r);
  assign stat.a_drop      = a_mod || ((base_r <= t_end) && (end_r >= t_end));
  assign stat.i_less      = base_r < t_base;
  assign stat.f_small     = m_size < size_r;
  assign stat.f_below     = m_top <= start_r;
  assign stat.w_bad       = (lo_r >= top_r) || (top_r < size_r);
  assign stat.lo_le_cand  = lo_r <= cand_r;
  assign stat.jdx_lt_rcnt = jdx_r < rcnt_r;
  assign stat.r_meet      = (cand_r < (r_base + r_size)) && (r_base < cand_end_r);
  assign stat.r_short     = r_base < size_r;

  // operation decode
  always_comb begin
    base_nxt       = base_r;
    end_nxt        = end_r;
    size_nxt       = size_r;
    start_nxt      = start_r;
    mask_nxt       = mask_r;
    lo_nxt         = lo_r;
    top_nxt        = top_r;
    cand_nxt       = cand_r;
    cand_end_nxt   = cand_end_r;
    rend_nxt       = t_end;
    idx_nxt        = idx_r;
    jdx_nxt        = jdx_r;
    tsel_nxt       = tsel_r;
    lim_nxt        = lim_r;
    mcnt_nxt       = mcnt_r;
    rcnt_nxt       = rcnt_r;
    mz_nxt         = mz_r;
    rz_nxt         = rz_r;
    ms0z_nxt       = ms0z_r;
    rs0z_nxt       = rs0z_r;
    out_valid_nxt  = cmd.fin;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    w_en           = 1'b0;
    w_addr         = idx_r[AW-1:0];
    w_data         = {base_r, reg_size};
    tc             = t_cnt;
    tz             = tsel_r ? rz_r : mz_r;
    ts0            = t_s0z;

    case (cmd.op)
      OP_LOAD: begin
        base_nxt  = in_start_addr;
        size_nxt  = in_length;
        start_nxt = in_start_addr;
        mask_nxt  = ~({33'd0, in_alignment} - 64'd1);
        tsel_nxt  = (in_mode == MODE_ADD_RES);
        if (in_mode == MODE_FIND) begin
          end_nxt = (in_end_limit == 64'd0) ? lim_r : in_end_limit;
          idx_nxt = mcnt_r;
        end else begin
          end_nxt = in_start_addr + in_length;
          idx_nxt = '0;
        end
      end
      OP_IDX_INC: idx_nxt = idx_r + CW'(1);
      OP_IDX_DEC: idx_nxt = idx_r - CW'(1);
      OP_WR_MOD: begin
        w_en   = 1'b1;
        w_data = {base_r, mod_size};
      end
      OP_DROP_BEGIN: begin
        // after a front merge the base stays; otherwise take the entry's base
        if (!a_mod) begin
          base_nxt = t_base;
        end
        jdx_nxt = idx_r;
      end
      OP_SHIFT_WR: begin
        w_en    = 1'b1;
        w_addr  = jdx_r[AW-1:0];
        w_data  = {t_base, t_size};
        jdx_nxt = jdx_inc;
      end
      OP_SHIFT_END: begin
        tc = t_cnt - CW'(1);
        if (tc == '0) begin
          tc  = CNT_ONE;
          tz  = 1'b1;
          ts0 = 1'b1;
        end
      end
      OP_WR_EMPTY: begin
        w_en   = 1'b1;
        w_addr = '0;
      end
      OP_INS_BEGIN: jdx_nxt = t_cnt;
      OP_INS_MOVE: begin
        w_en    = 1'b1;
        w_addr  = jdx_r[AW-1:0];
        w_data  = {t_base, t_size};
        jdx_nxt = jdx_dec;
      end
      OP_INS_PLACE: begin
        w_en   = 1'b1;
        w_addr = jdx_r[AW-1:0];
      end
      OP_INS_FIX0: begin
        w_en   = stat.i_less;
        w_addr = '0;
        tc     = t_cnt + CW'(1);
      end
      OP_F_WIN: begin
        lo_nxt  = (m_base > start_r) ? m_base : start_r;
        top_nxt = (m_top < end_r) ? m_top : end_r;
      end
      OP_F_CAND: begin
        cand_nxt = (top_r - size_r) & mask_r;
        lo_nxt   = (lo_r == 64'd0) ? PAGE : lo_r;
      end
      OP_F_LOOP: begin
        cand_end_nxt = cand_r + size_r;
        jdx_nxt      = '0;
      end
      OP_R_INC:  jdx_nxt  = jdx_inc;
      OP_R_STEP: cand_nxt = (r_base - size_r) & mask_r;
      default: begin
      end
    endcase

    // a write to entry zero makes it real
    if (w_en && (w_addr == '0)) begin
      tz  = 1'b0;
      ts0 = (w_data[63:0] == 64'd0);
    end

    if (tsel_r) begin
      rcnt_nxt = tc;
      rz_nxt   = tz;
      rs0z_nxt = ts0;
    end else begin
      mcnt_nxt = tc;
      mz_nxt   = tz;
      ms0z_nxt = ts0;
    end

    // result register
    if (cmd.fin) begin
      out_status_nxt = cmd.fin_status;
      out_addr_nxt   = cmd.fin_hit ? cand_r : 64'd0;
    end

    if (cfg_valid) begin
      lim_nxt = cfg_alloc_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mcnt_r      <= CNT_ONE;
      rcnt_r      <= CNT_ONE;
      mz_r        <= 1'b1;
      rz_r        <= 1'b1;
      ms0z_r      <= 1'b1;
      rs0z_r      <= 1'b1;
      out_valid_r <= 1'b0;
      lim_r       <= '1;
    end else begin
      mcnt_r      <= mcnt_nxt;
      rcnt_r      <= rcnt_nxt;
      mz_r        <= mz_nxt;
      rz_r        <= rz_nxt;
      ms0z_r      <= ms0z_nxt;
      rs0z_r      <= rs0z_nxt;
      out_valid_r <= out_valid_nxt;
      lim_r       <= lim_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r       <= base_nxt;
    end_r        <= end_nxt;
    size_r       <= size_nxt;
    start_r      <= start_nxt;
    mask_r       <= mask_nxt;
    lo_r         <= lo_nxt;
    top_r        <= top_nxt;
    cand_r       <= cand_nxt;
    cand_end_r   <= cand_end_nxt;
    rend_r       <= rend_nxt;
    idx_r        <= idx_nxt;
    jdx_r        <= jdx_nxt;
    tsel_r       <= tsel_nxt;
    mzq_r        <= mzq_nxt;
    rzq_r        <= rzq_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_found_addr = out_addr_r;

endmodule

// ----- src/boot_region_table_allocator.sv -----
`timescale 1ns / 1ps

// Boot region table allocator. A request is taken when start is high and busy
// is low; its single result is registered and appears in the cycle after the
// request completes, with out_valid high for exactly one cycle, and must be
// captured then: the result side cannot stall. Every table access is an
// address, then registered read data from the table RAM. An add scans the
// table entries and moves entries for each merged entry and for the sorted
// insert, up to the case where one add swallows a full table of 128 entries.
// A find visits memory entries and, for each candidate position, checks the
// reserved entries. An unused mode is answered straight from idle, without a
// table access. The alloc_limit register accepts a write on every cycle and
// should only be written while busy is low.
module boot_region_table_allocator import brta_pkg::*; #(
  parameter int MAX_REGIONS = 128,
  parameter int PAGE_BYTES  = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [63:0] in_start_addr,
  input  logic [63:0] in_length,
  input  logic [63:0] in_end_limit,
  input  logic [30:0] in_alignment,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [63:0] out_found_addr,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_alloc_limit
);

  brta_cmd_t  cmd;
  brta_stat_t stat;

  assign cfg_ready = 1'b1;

  brta_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  brta_dp #(
    .MAX_REGIONS (MAX_REGIONS),
    .PAGE_BYTES  (PAGE_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_mode         (in_mode),
    .in_start_addr   (in_start_addr),
    .in_length       (in_length),
    .in_end_limit    (in_end_limit),
    .in_alignment    (in_alignment),
    .cfg_valid       (cfg_valid && cfg_ready),
    .cfg_alloc_limit (cfg_alloc_limit),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_found_addr  (out_found_addr)
  );

  // a result is only presented once the controller is back to idle
  a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // a result follows a transaction in flight or one just taken
  a_res_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(start)))
    else $error("result without a transaction");

  a_res_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_DONE || out_status == ST_FULL ||
                   out_status == ST_NOSPACE))
    else $error("bad result status");

  // an address is only reported on success
  a_res_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_DONE) |-> (out_found_addr == 64'd0))
    else $error("address reported on failure");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import brta_pkg::*;

  localparam int         SLOTS       = 128;
  localparam logic [63:0] PAGE       = 64'd4096;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         TBL_MEM     = 0;
  localparam int         TBL_RES     = 1;
  localparam longint     CYCLE_LIMIT = 40_000_000;
  localparam int         DRAIN       = 64;

  typedef struct {
    logic [1:0]  mode;
    logic [63:0] base;
    logic [63:0] len;
    logic [63:0] lim;
    logic [30:0] align;
  } request_t;

  typedef struct {
    logic [1:0]  status;
    logic [63:0] addr;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_mode = '0;
  logic [63:0] in_start_addr = '0;
  logic [63:0] in_length = '0;
  logic [63:0] in_end_limit = '0;
  logic [30:0] in_alignment = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [63:0] out_found_addr;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [63:0] cfg_alloc_limit = '0;

  // shadow copy of both region tables and the limit register
  logic [63:0] row_base [2][SLOTS];
  logic [63:0] row_size [2][SLOTS];
  int          row_count [2];
  logic [63:0] limit_shadow;

  answer_t     awaited_answers[$];
  int          fail_count = 0;
  longint      cycle_count = 0;
  int          idle_pct = 0;

  boot_region_table_allocator uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_start_addr(in_start_addr), .in_length(in_length),
    .in_end_limit(in_end_limit), .in_alignment(in_alignment),
    .out_valid(out_valid), .out_status(out_status), .out_found_addr(out_found_addr),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_alloc_limit(cfg_alloc_limit)
  );

  always #5 clk = ~clk;

  // ---------------- region table predictor ----------------

  function automatic void remove_row(int t, int idx);
    for (int k = idx; k + 1 < row_count[t]; k++) begin
      row_base[t][k] = row_base[t][k + 1];
      row_size[t][k] = row_size[t][k + 1];
    end
    row_count[t]--;
    if (row_count[t] == 0) begin
      row_count[t] = 1;
      row_base[t][0] = '0;
      row_size[t][0] = '0;
    end
  endfunction

  function automatic logic [1:0] merge_region(int t, logic [63:0] base, logic [63:0] size);
    logic [63:0] stop;
    logic [63:0] rb;
    logic [63:0] rend;
    int i;
    stop = base + size;
    i = 0;
    while (i < row_count[t] && i < SLOTS) begin
      rb = row_base[t][i];
      rend = rb + row_size[t][i];
      if (rb > stop || row_size[t][i] == 0) break;
      if (rb <= base && rend >= stop) return ST_DONE;
      // new region reaches down below this entry
      if (base < rb && stop >= rb) begin
        row_base[t][i] = base;
        row_size[t][i] = rend - base;
        if (rend >= stop) return ST_DONE;
        base = rend;
        size = stop - base;
      end
      // overlaps or touches the top: absorb the entry and rescan
      if (base <= rend && stop >= rend) begin
        size = size + (base - row_base[t][i]);
        base = row_base[t][i];
        remove_row(t, i);
        continue;
      end
      i++;
    end
    if (row_count[t] == 1 && row_size[t][0] == 0) begin
      row_base[t][0] = base;
      row_size[t][0] = size;
      return ST_DONE;
    end
    if (row_count[t] >= SLOTS) return ST_FULL;
    // sorted insert
    for (int k = row_count[t]; k > 0; k--) begin
      if (base < row_base[t][k - 1]) begin
        row_base[t][k] = row_base[t][k - 1];
        row_size[t][k] = row_size[t][k - 1];
      end else begin
        row_base[t][k] = base;
        row_size[t][k] = size;
        break;
      end
    end
    if (base < row_base[t][0]) begin
      row_base[t][0] = base;
      row_size[t][0] = size;
    end
    row_count[t]++;
    return ST_DONE;
  endfunction

  function automatic bit window_fit(logic [63:0] lo, logic [63:0] hi, logic [63:0] size,
                                    logic [63:0] mask, output logic [63:0] hit);
    logic [63:0] cand;
    logic [63:0] rb;
    logic [63:0] rtop;
    logic [63:0] ctop;
    bit clash;
    hit = '0;
    if (hi < size) return 0;
    cand = (hi - size) & mask;
    if (lo == 0) lo = PAGE;
    while (lo <= cand) begin
      clash = 0;
      rb = '0;
      ctop = cand + size;
      for (int j = 0; j < row_count[TBL_RES] && j < SLOTS; j++) begin
        rtop = row_base[TBL_RES][j] + row_size[TBL_RES][j];
        if (cand < rtop && row_base[TBL_RES][j] < ctop) begin
          clash = 1;
          rb = row_base[TBL_RES][j];
          break;
        end
      end
      if (!clash) begin
        hit = cand;
        return 1;
      end
      // step below the reserved entry, give up if it sits under the block size
      if (rb < size) return 0;
      cand = (rb - size) & mask;
    end
    return 0;
  endfunction

  function automatic bit locate_block(request_t r, output logic [63:0] hit);
    logic [63:0] mask;
    logic [63:0] top_lim;
    logic [63:0] mb;
    logic [63:0] mtop;
    logic [63:0] bottom;
    logic [63:0] top;
    hit = '0;
    mask = ~({33'd0, r.align} - 64'd1);
    top_lim = (r.lim == 0) ? limit_shadow : r.lim;
    for (int k = row_count[TBL_MEM]; k > 0; k--) begin
      mb = row_base[TBL_MEM][k - 1];
      mtop = mb + row_size[TBL_MEM][k - 1];
      if (row_size[TBL_MEM][k - 1] < r.len) continue;
      if (mtop <= r.base) break;
      bottom = (mb > r.base) ? mb : r.base;
      top = (mtop < top_lim) ? mtop : top_lim;
      if (bottom >= top) continue;
      if (window_fit(bottom, top, r.len, mask, hit)) return 1;
    end
    hit = '0;
    return 0;
  endfunction

  function automatic answer_t predict_answer(request_t r);
    answer_t a;
    a.status = ST_DONE;
    a.addr = '0;
    case (r.mode)
      MODE_ADD_MEM: a.status = merge_region(TBL_MEM, r.base, r.len);
      MODE_ADD_RES: a.status = merge_region(TBL_RES, r.base, r.len);
      MODE_FIND: begin
        if (!locate_block(r, a.addr)) a.status = ST_NOSPACE;
      end
      default: ;
    endcase
    return a;
  endfunction

  // ---------------- driving ----------------

  // called just after a rising edge; returns at the edge that takes the transaction
  task automatic send_request(request_t r);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= r.mode;
    in_start_addr <= r.base;
    in_length <= r.len;
    in_end_limit <= r.lim;
    in_alignment <= r.align;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    awaited_answers.push_back(predict_answer(r));
  endtask

  task automatic send(logic [1:0] mode, logic [63:0] base, logic [63:0] len,
                      logic [63:0] lim, logic [30:0] align);
    request_t r;
    r = '{mode, base, len, lim, align};
    send_request(r);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (awaited_answers.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_limit(logic [63:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_alloc_limit <= value;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    limit_shadow = value;
  endtask

  // mostly page-grained regions in a 16 MiB span, with some full-width noise
  function automatic request_t random_request();
    request_t r;
    int pick;
    bit noisy;
    pick = $urandom_range(99);
    r.mode = (pick < 35) ? MODE_ADD_MEM : (pick < 58) ? MODE_ADD_RES :
             (pick < 95) ? MODE_FIND : MODE_UNUSED;
    noisy = $urandom_range(99) < ((r.mode == MODE_FIND || r.mode == MODE_UNUSED) ? 6 : 1);
    if (noisy) begin
      r.base = {$urandom, $urandom};
      r.len = {$urandom, $urandom};
      r.lim = {$urandom, $urandom};
      r.align = 31'($urandom);
    end else begin
      r.base = 64'($urandom_range(0, 4095)) * PAGE;
      if ($urandom_range(3) == 0) r.base += 64'($urandom_range(0, 4095));
      if ($urandom_range(9) == 0) r.base |= 64'hFFFF_FFFF_0000_0000;
      if (r.mode == MODE_FIND) r.len = 64'($urandom_range(1, 8)) * PAGE;
      else r.len = 64'($urandom_range(0, 16)) * PAGE;
      if ($urandom_range(4) == 0) r.len += 64'($urandom_range(1, 4095));
      r.lim = ($urandom_range(3) == 0) ? 64'd0 : r.base + 64'($urandom_range(1, 1024)) * PAGE;
      r.align = 31'd1 << (($urandom_range(19) == 0) ? $urandom_range(15, 30)
                                                    : $urandom_range(0, 14));
    end
    return r;
  endfunction

  // ---------------- result checking ----------------

  always @(posedge clk) begin
    answer_t exp_a;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
    if (rst_n && out_valid === 1'b1) begin
      if (awaited_answers.size() == 0) begin
        $display("%0t: unexpected result status=%0d addr=%h", $time, out_status,
                 out_found_addr);
        fail_count++;
      end else begin
        exp_a = awaited_answers.pop_front();
        if (out_status !== exp_a.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_a.status, out_status);
          fail_count++;
        end
        if (out_found_addr !== exp_a.addr) begin
          $display("%0t: found_addr expected %h actual %h", $time, exp_a.addr,
                   out_found_addr);
          fail_count++;
        end
      end
    end
  end

  // ---------------- tests ----------------

  task automatic test_directed();
    idle_pct = 0;
    send(MODE_UNUSED, '1, '1, '1, '1);
    send(MODE_FIND, 0, PAGE, 0, 31'd1);                     // empty tables
    send(MODE_ADD_MEM, 64'h1000, 0, 0, 0);                  // zero length into empty table
    send(MODE_ADD_MEM, 64'h0, 64'h10_0000, 0, 0);
    send(MODE_ADD_MEM, 64'h10_0000, 64'h10_0000, 0, 0);     // touching, merges
    send(MODE_ADD_MEM, 64'h8000, 64'h1000, 0, 0);           // already covered
    send(MODE_ADD_MEM, 64'h100_0000, 64'h1_0000, 0, 0);     // sorted insert above
    send(MODE_ADD_RES, 64'h1F_0000, 64'h1_0000, 0, 0);
    send(MODE_FIND, 0, 64'h1000, 0, 31'h1000);
    send(MODE_FIND, 0, 64'h1000, 64'h20_0000, 31'h1000);    // steps under reserved
    send(MODE_FIND, 0, 64'h1000, 0, 31'd0);                 // zero alignment
    send(MODE_FIND, 0, 64'h1000, 64'h1F_F000, 31'd3);       // odd alignment
    send(MODE_FIND, 0, 64'h30_0000, 0, 31'd1);              // longer than any window
    send(MODE_ADD_RES, 64'h0, 64'h800, 0, 0);
    send(MODE_FIND, 0, 64'h1000, 64'h2000, 31'd1);          // start zero raised to a page
    send(MODE_ADD_RES, 64'h1000, 64'h1E_F000, 0, 0);
    send(MODE_FIND, 0, 64'h2000, 64'h20_0000, 31'd1);       // reserved below block size
    send(MODE_ADD_MEM, 64'hFFFF_FFFF_FFFF_F000, 64'h2000, 0, 0); // wraps
    send(MODE_FIND, '1, '1, '1, 31'h4000_0000);
    send(MODE_FIND, 64'h100_0000, 64'h100, '1, 31'h7FFF_FFFF);
    send(MODE_FIND, 64'h100_0000, 64'h100, 0, 31'h4000_0000);
    drain();
  endtask

  task automatic test_limit_register();
    logic [63:0] lims [4];
    lims = '{64'd0, 64'h100_8000, 64'h8000_0000_0000_0000, '1};
    idle_pct = 54;
    foreach (lims[i]) begin
      write_limit(lims[i]);
      send(MODE_FIND, 0, 64'h1000, 0, 31'h1000);
      send(MODE_FIND, 64'h100_0000, 64'h100, 0, 31'd16);
    end
  endtask

  task automatic test_random_traffic();
    int pcts [5];
    logic [63:0] lims [5];
    pcts = '{0, 54, 29, 0, 54};
    lims = '{'1, 64'h80_0000, 64'd0, 64'hFFFF_FFFF_8000_0000, '1};
    foreach (pcts[p]) begin
      write_limit(($urandom_range(1) == 0) ? lims[p] : {$urandom, $urandom});
      idle_pct = pcts[p];
      repeat (232) send_request(random_request());
    end
    drain();
  endtask

  // fill both tables with disjoint high regions until they report full
  task automatic test_table_full();
    idle_pct = 29;
    for (int k = 0; k < SLOTS + 2; k++)
      send(MODE_ADD_MEM, 64'hC000_0000_0000_0000 + 64'(k) * 64'h2000, 64'h1000, 0, 0);
    for (int k = 0; k < SLOTS + 2; k++)
      send(MODE_ADD_RES, 64'hC000_0000_0000_0800 + 64'(k) * 64'h4000, 64'h100, 0, 0);
    send(MODE_FIND, 64'hC000_0000_0000_0000, 64'h800, 0, 31'h100);
    send(MODE_FIND, 0, 64'h1000, 0, 31'h1000);
    drain();
  endtask

  initial begin
    foreach (row_base[t, i]) begin
      row_base[t][i] = '0;
      row_size[t][i] = '0;
    end
    row_count[TBL_MEM] = 1;
    row_count[TBL_RES] = 1;
    limit_shadow = '1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_limit_register();
    test_random_traffic();
    test_table_full();
    if (fail_count == 0 && awaited_answers.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
